### hw/rtl/rsi_pkg.sv
// rsi_pkg: shared constants for the ray/sphere intersection block.
// No dependencies; used by the interfaces and the top level.
package rsi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int DIR_WIDTH   = 18;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_IDX_W   = 3;

  localparam longint CENTER_Z_RESET = 64'd131072;  // 2.0
  localparam longint RADIUS_RESET   = 64'd65536;   // 1.0

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_RADIUS   = 3'd3,
    CFG_MIN_DIST = 3'd4,
    CFG_MAX_DIST = 3'd5
  } cfg_idx_t;

endpackage

### hw/rtl/rsi_if.sv
// rsi_if: valid/ready channels for rays in and intersection results out.
// Depends on rsi_pkg.
interface rsi_ray_if #(
  parameter int W = rsi_pkg::COORD_WIDTH
);
  logic                                 valid;
  logic                                 ready;
  logic signed [W-1:0]                  origin_x;
  logic signed [W-1:0]                  origin_y;
  logic signed [W-1:0]                  origin_z;
  logic signed [rsi_pkg::DIR_WIDTH-1:0] dir_x;
  logic signed [rsi_pkg::DIR_WIDTH-1:0] dir_y;
  logic signed [rsi_pkg::DIR_WIDTH-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rsi_hit_if #(
  parameter int W = rsi_pkg::COORD_WIDTH
);
  logic         valid;
  logic         ready;
  logic         hit;
  logic [W-2:0] hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink   (input valid, hit, hit_distance, output ready);
endinterface

### hw/rtl/ray_sphere_intersection.sv
// Throughput: one ray per cycle while res.ready holds; the square root resolves one
// result bit per stage, and its COORD_WIDTH+5 stages set the depth.
// Each stage holds its item until the next stage frees, so bubbles close up.
// Reset (synchronous, rst high) empties the pipeline and loads the default sphere.
// Depends on rsi_pkg and rsi_if.
module ray_sphere_intersection #(
  parameter int W = rsi_pkg::COORD_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [W-1:0]                    cfg_data,
  rsi_ray_if.sink                         ray,
  rsi_hit_if.source                       res
);

  localparam int DW  = rsi_pkg::DIR_WIDTH;
  localparam int FB  = rsi_pkg::FRAC_BITS;
  localparam int OW  = W + 1;           // centre offset
  localparam int PW  = OW + DW;         // d*o
  localparam int SW  = PW + 2;          // sum of three d*o
  localparam int BW  = SW - FB;         // b
  localparam int QW  = 2 * OW;          // o*o
  localparam int CW  = QW + 3;          // c
  localparam int BBW = 2 * BW;          // b*b
  localparam int DSW = BBW + 1;         // discriminant, signed
  localparam int DUW = DSW - 1;         // positive discriminant
  localparam int SQW = DUW / 2;         // root bits
  localparam int TW  = BW + 1;          // b -/+ s
  localparam int NST = 6 + SQW;

  // configuration
  logic signed [W-1:0] center_x, center_y, center_z;
  logic [W-2:0]        sphere_radius, min_distance, max_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= W'(rsi_pkg::CENTER_Z_RESET);
      sphere_radius <= (W-1)'(rsi_pkg::RADIUS_RESET);
      min_distance  <= '0;
      max_distance  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsi_pkg::CFG_CENTER_X: center_x      <= cfg_data;
        rsi_pkg::CFG_CENTER_Y: center_y      <= cfg_data;
        rsi_pkg::CFG_CENTER_Z: center_z      <= cfg_data;
        rsi_pkg::CFG_RADIUS:   sphere_radius <= cfg_data[W-2:0];
        rsi_pkg::CFG_MIN_DIST: min_distance  <= cfg_data[W-2:0];
        rsi_pkg::CFG_MAX_DIST: max_distance  <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // per-stage flow control
  logic [NST-1:0] v;
  logic [NST-1:0] adv;

  genvar gi;
  generate
    for (gi = 0; gi < NST - 1; gi++) begin : g_adv
      assign adv[gi] = !v[gi] || adv[gi+1];
    end
  endgenerate
  assign adv[NST-1] = !v[NST-1] || res.ready;
  assign ray.ready  = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= ray.valid;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // stage 1: offset to centre
  logic signed [OW-1:0] s1_ox, s1_oy, s1_oz;
  logic signed [DW-1:0] s1_dx, s1_dy, s1_dz;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_ox <= OW'(center_x) - OW'(ray.origin_x);
      s1_oy <= OW'(center_y) - OW'(ray.origin_y);
      s1_oz <= OW'(center_z) - OW'(ray.origin_z);
      s1_dx <= ray.dir_x;
      s1_dy <= ray.dir_y;
      s1_dz <= ray.dir_z;
    end
  end

  // stage 2: products
  logic signed [PW-1:0] s2_px, s2_py, s2_pz;
  logic signed [QW-1:0] s2_qx, s2_qy, s2_qz;
  logic [2*W-3:0]       s2_rr;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_px <= PW'(s1_dx) * PW'(s1_ox);
      s2_py <= PW'(s1_dy) * PW'(s1_oy);
      s2_pz <= PW'(s1_dz) * PW'(s1_oz);
      s2_qx <= QW'(s1_ox) * QW'(s1_ox);
      s2_qy <= QW'(s1_oy) * QW'(s1_oy);
      s2_qz <= QW'(s1_oz) * QW'(s1_oz);
      s2_rr <= (2*W-2)'(sphere_radius) * (2*W-2)'(sphere_radius);
    end
  end

  // stage 3: b (floored to Q16.16) and c
  logic signed [SW-1:0] s3_bsum;
  logic signed [BW-1:0] s3_b;
  logic signed [CW-1:0] s3_c;

  assign s3_bsum = SW'(s2_px) + SW'(s2_py) + SW'(s2_pz);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_b <= s3_bsum[SW-1:FB];
      s3_c <= CW'(s2_qx) + CW'(s2_qy) + CW'(s2_qz) - $signed(CW'(s2_rr));
    end
  end

  // stage 4: b squared
  logic signed [BBW-1:0] s4_bb;
  logic signed [BW-1:0]  s4_b;
  logic signed [CW-1:0]  s4_c;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_bb <= BBW'(s3_b) * BBW'(s3_b);
      s4_b  <= s3_b;
      s4_c  <= s3_c;
    end
  end

  // stage 5: discriminant, then the root pipeline
  logic signed [DSW-1:0] s5_dsc;
  logic [DUW-1:0]        sq_rem  [SQW+1];
  logic [SQW-1:0]        sq_root [SQW+1];
  logic signed [BW-1:0]  sq_b    [SQW+1];
  logic                  sq_pos  [SQW+1];

  assign s5_dsc = DSW'(s4_bb) - DSW'(s4_c);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      sq_rem[0]  <= s5_dsc[DUW-1:0];
      sq_root[0] <= '0;
      sq_b[0]    <= s4_b;
      sq_pos[0]  <= (s5_dsc > 0);
    end
  end

  generate
    for (gi = 0; gi < SQW; gi++) begin : g_sqrt
      localparam int K = SQW - 1 - gi;
      logic [DUW:0] trial;
      logic         take;

      // try setting root bit K: needs (root << (K+1)) + 4^K <= remainder
      assign trial = (DUW'(sq_root[gi]) << (K + 1)) | ((DUW+1)'(1) << (2 * K));
      assign take  = trial <= {1'b0, sq_rem[gi]};

      always_ff @(posedge clk) begin
        if (adv[5+gi]) begin
          sq_rem[gi+1]  <= take ? sq_rem[gi] - trial[DUW-1:0] : sq_rem[gi];
          sq_root[gi+1] <= take ? sq_root[gi] | (SQW'(1) << K) : sq_root[gi];
          sq_b[gi+1]    <= sq_b[gi];
          sq_pos[gi+1]  <= sq_pos[gi];
        end
      end
    end
  endgenerate

  // last stage: pick the nearer root inside the window
  logic signed [TW-1:0] t_near, t_far, t_lo, t_hi, t_sel;
  logic                 near_ok, far_ok, hit_next;
  logic                 max_inf;

  assign t_lo    = $signed({{(TW-W+1){1'b0}}, min_distance});
  assign t_hi    = $signed({{(TW-W+1){1'b0}}, max_distance});
  assign max_inf = &max_distance;
  assign t_near  = TW'(sq_b[SQW]) - $signed({1'b0, sq_root[SQW]});
  assign t_far   = TW'(sq_b[SQW]) + $signed({1'b0, sq_root[SQW]});
  assign near_ok = (t_near > t_lo) && (max_inf || t_near < t_hi);
  assign far_ok  = (t_far > t_lo) && (max_inf || t_far < t_hi);
  assign hit_next = sq_pos[SQW] && (near_ok || far_ok);
  assign t_sel   = near_ok ? t_near : t_far;

  always_ff @(posedge clk) begin
    if (adv[NST-1]) begin
      res.hit <= hit_next;
      if (!hit_next || t_sel > $signed({{(TW-W+1){1'b0}}, {(W-1){1'b1}}}))
        res.hit_distance <= '1;
      else
        res.hit_distance <= t_sel[W-2:0];
    end
  end

  assign res.valid = v[NST-1];

  a_miss_max: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.hit |-> &res.hit_distance)
    else $error("miss without saturated distance");

  // a far hit saturates, which may equal a window floor of all ones
  a_hit_above_min: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.hit |-> res.hit_distance > min_distance || &res.hit_distance)
    else $error("hit at or below window floor");

  a_hit_below_max: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.hit && !(&max_distance) |-> res.hit_distance < max_distance)
    else $error("hit at or beyond window ceiling");

endmodule
